// ----- sv/f64rp2_pkg.sv -----
// Shared types and constants for the binary64 power-of-two rounding pipeline.
// No dependencies.
package f64rp2_pkg;
	localparam int unsigned MantBits = 52;
	localparam int unsigned ExpBits = 11;
	localparam int unsigned SignPos = 64 - 1;
	localparam logic [ExpBits-1:0] ExpMax = 11'h7FF;
	localparam logic [ExpBits-1:0] Bias = 11'd1023;
	localparam logic [ExpBits-1:0] HalfExp = 11'd1022;

	typedef logic [63:0] word_t;

	// how the round stage treats a pattern, chosen from its exponent
	typedef enum logic [1:0] {
		KindPass,
		KindRound,
		KindHalf,
		KindZero
	} round_kind_t;

	typedef struct packed {
		word_t value_bits;
		word_t scale_bits;
	} in_item_t;

	typedef struct packed {
		word_t result_bits;
		logic domain_error;
	} out_item_t;
endpackage

// ----- sv/f64rp2_stream_if.sv -----
// Valid/ready channel carrying one item of a given payload type.
// No dependencies; the payload type is a parameter.
interface f64rp2_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/float64_round_to_power_of_two_step.sv -----
// Rounds a binary64 value to the nearest multiple of 2^(scale exponent + 1).
// Throughput one item per cycle, stall holds all stages.
// Stage 1 subtracts the exponent offset, stage 2 rounds, stage 3 adds it back.
// Reset (arst_n low, asynchronous) clears the valid bits; data is not reset.
module float64_round_to_power_of_two_step
	import f64rp2_pkg::*;
(
	input logic clk,
	input logic arst_n,
	f64rp2_stream_if.sink in_ch,
	f64rp2_stream_if.source out_ch
);
	logic adv;
	logic v_s1, v_s2, v_s3;
	word_t a_s1, n_s1, n_s2, r_s2, res_s3;
	logic [MantBits:0] unit_s1;
	round_kind_t kind_s1;
	logic err_s1, err_s2, err_s3;

	word_t a_c, n_c, r_c;
	logic [ExpBits-1:0] e_c, se_c, ve_c;
	logic [ExpBits:0] fb_c;
	round_kind_t kind_c;
	logic signed [ExpBits+1:0] sh_c;
	logic err_c;

	assign adv = !v_s3 || out_ch.ready;
	assign in_ch.ready = adv;

	always_comb begin
		n_c = {1'b0, in_ch.data.scale_bits[62:52], 52'd0} - {1'b0, HalfExp, 52'd0};
		a_c = in_ch.data.value_bits - n_c;
		e_c = a_c[62:52];
		fb_c = {1'b0, Bias} + 12'(MantBits) - {1'b0, e_c};
		if (e_c == ExpMax) kind_c = KindPass;
		else if ({1'b0, e_c} >= {1'b0, Bias} + 12'(MantBits)) kind_c = KindPass;
		else if (e_c >= Bias) kind_c = KindRound;
		else if (e_c == Bias - 11'd1) kind_c = KindHalf;
		else kind_c = KindZero;
		se_c = in_ch.data.scale_bits[62:52];
		ve_c = in_ch.data.value_bits[62:52];
		sh_c = $signed({2'b0, ve_c}) - $signed({2'b0, se_c}) + 13'sd1022;
		err_c = in_ch.data.scale_bits[63] || se_c == '0 || se_c == ExpMax
			|| ve_c == ExpMax || (ve_c == '0 && in_ch.data.value_bits[51:0] != '0)
			|| sh_c < 13'sd1 || sh_c > 13'sd2046;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// NaN quieting folded into stage 1 input of the round
			a_s1 <= (e_c == ExpMax && a_c[51:0] != '0) ? (a_c | (64'd1 << 51)) : a_c;
			n_s1 <= n_c;
			err_s1 <= err_c;
			kind_s1 <= kind_c;
			unit_s1 <= (MantBits+1)'(1) << fb_c[5:0];
			r_s2 <= r_c;
			n_s2 <= n_s1;
			err_s2 <= err_s1;
			res_s3 <= (r_s2[62:0] != '0) ? r_s2 + n_s2 : r_s2;
			err_s3 <= err_s2;
		end
	end

	f64rp2_round u_round (.x(a_s1), .unit_mask(unit_s1), .kind(kind_s1), .y(r_c));

	assign out_ch.valid = v_s3;
	assign out_ch.data.result_bits = res_s3;
	assign out_ch.data.domain_error = err_s3;
endmodule

// ----- sv/f64rp2_round.sv -----
// Combinational round-to-integer (ties to even) on a binary64 pattern,
// given the unit bit computed in the previous stage. Uses f64rp2_pkg.
module f64rp2_round
	import f64rp2_pkg::*;
(
	input  word_t x,
	input  logic [MantBits:0] unit_mask,
	input  round_kind_t kind,
	output word_t y
);
	// pass-through, masked round, round to one-or-zero, or straight to zero
	logic [62:0] mag;
	logic [62:0] mask;
	logic [62:0] unit;
	logic [62:0] half;
	logic [62:0] frac;
	logic [62:0] trunc;
	logic up;

	always_comb begin
		mag = x[62:0];
		unit = {{(62-MantBits){1'b0}}, unit_mask};
		mask = unit - 63'd1;
		half = unit >> 1;
		frac = mag & mask;
		trunc = mag & ~mask;
		up = (frac > half) || ((frac == half) && ((trunc & unit) != 63'd0));
		case (kind)
			KindPass: y = x;
			KindRound: y = {x[63], up ? trunc + unit : trunc};
			KindHalf: y = {x[63], (x[MantBits-1:0] != '0) ? {1'b0, Bias[9:0], 52'd0} : 63'd0};
			default: y = {x[63], 63'd0};
		endcase
	end
endmodule

// ----- sv/f64rp2_checker.sv -----
// Port-level checks on the rounding pipeline, bound to the top level.
// Depends on f64rp2_pkg and the top level's ports.
module f64rp2_checker
	import f64rp2_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input word_t out_result
);
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("stalled with empty output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_result))
		else $error("stalled item changed");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("item lost in pipeline");
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("ready while stalled");
endmodule

bind float64_round_to_power_of_two_step f64rp2_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_result(out_ch.data.result_bits)
);

// ----- dv/tb_top.sv -----
// Testbench for float64_round_to_power_of_two_step: random and directed binary64 items,
// bit-level predictor, in-order scoreboard. Depends on f64rp2_pkg, f64rp2_stream_if.
module tb_top
	import f64rp2_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam word_t SignMask = 64'h8000_0000_0000_0000;
	localparam word_t MagMask = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam word_t MantMask = 64'h000F_FFFF_FFFF_FFFF;
	localparam word_t ExpMask = 64'h7FF0_0000_0000_0000;
	localparam word_t OneBits = 64'h3FF0_0000_0000_0000;
	localparam int CycleLimit = 400000;
	localparam int Latency = 3;

	logic clk;
	logic arst_n;
	f64rp2_stream_if #(.payload_t(in_item_t)) in_ch ();
	f64rp2_stream_if #(.payload_t(out_item_t)) out_ch ();

	float64_round_to_power_of_two_step u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	in_item_t pending_items[$];
	out_item_t expected_rounds[$];
	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;

	// round a binary64 pattern to an integer, ties to even
	function automatic word_t round_to_int(word_t x);
		word_t sgn, mag, unit_w, half_w, mask_w, frac;
		int e, fb;
		sgn = x & SignMask;
		mag = x & MagMask;
		e = int'(mag[62:52]);
		if (e == int'(ExpMax)) begin
			if ((mag & MantMask) != 0) return x | (64'd1 << (MantBits - 1));
			return x;
		end
		if (e >= int'(Bias) + int'(MantBits)) return x;
		if (e >= int'(Bias)) begin
			fb = int'(Bias) + int'(MantBits) - e;
			unit_w = 64'd1 << fb;
			half_w = unit_w >> 1;
			mask_w = unit_w - 1;
			frac = mag & mask_w;
			mag = mag & ~mask_w;
			if (frac > half_w || (frac == half_w && mag[fb])) mag = mag + unit_w;
			return sgn | mag;
		end
		if (e == int'(Bias) - 1) return sgn | (((x & MantMask) != 0) ? OneBits : 64'd0);
		return sgn;
	endfunction

	function automatic out_item_t predict_round(in_item_t it);
		out_item_t o;
		word_t offs, r;
		int se, ve, sh;
		offs = (it.scale_bits & ExpMask) - (word_t'(HalfExp) << MantBits);
		r = round_to_int(it.value_bits - offs);
		if ((r & MagMask) != 0) r = r + offs;
		se = int'(it.scale_bits[62:52]);
		ve = int'(it.value_bits[62:52]);
		sh = ve - se + int'(HalfExp);
		o.result_bits = r;
		o.domain_error = it.scale_bits[63] || se == 0 || se == int'(ExpMax)
			|| ve == int'(ExpMax) || (ve == 0 && (it.value_bits & MantMask) != 0)
			|| sh < 1 || sh > 2046;
		return o;
	endfunction

	function automatic word_t mk_f64(bit s, int e, word_t m);
		return {s, 11'(e), 52'(m)};
	endfunction

	function automatic word_t rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// mostly well-formed pairs with the shifted exponent near the rounding range
	function automatic in_item_t rand_item();
		in_item_t it;
		int se, k;
		k = $urandom_range(0, 99);
		if (k < 75) begin
			se = $urandom_range(1, 2046);
			it.scale_bits = mk_f64($urandom_range(0, 19) == 0, se, rand_word());
			it.value_bits = mk_f64($urandom_range(0, 1), se + $urandom_range(0, 60) - 2,
				rand_word());
			if ($urandom_range(0, 4) == 0)
				it.value_bits[20:0] = $urandom_range(0, 1) ? 21'h100000 : 21'h0;
		end else begin
			it.value_bits = rand_word();
			it.scale_bits = rand_word();
		end
		return it;
	endfunction

	task automatic add_item(word_t v, word_t s);
		in_item_t it;
		it.value_bits = v;
		it.scale_bits = s;
		pending_items.push_back(it);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (pending_items.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
				expected_rounds.push_back(predict_round(pending_items[0]));
				in_ch.data <= pending_items.pop_front();
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver stall, with an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= $urandom_range(1, 100) > recv_stall_pct;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_rounds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: result %h err %b",
						out_ch.data.result_bits, out_ch.data.domain_error);
			end else begin
				if (out_ch.data !== expected_rounds[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h/%b got %h/%b",
							expected_rounds[0].result_bits,
							expected_rounds[0].domain_error,
							out_ch.data.result_bits, out_ch.data.domain_error);
				end
				void'(expected_rounds.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("** float64_round_to_power_of_two_step: FAILED **");
			$finish;
		end
	end

	task automatic drain();
		while (pending_items.size() != 0 || expected_rounds.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n) pending_items.push_back(rand_item());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, ties, zeros, specials, bad scales, range edges
		add_item(64'h0, mk_f64(0, 1023, 0));
		add_item(SignMask, mk_f64(0, 1023, 0));
		add_item(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(mk_f64(0, 1023, 64'h8_0000_0000_0000), mk_f64(0, 1022, 0));
		add_item(mk_f64(0, 1024, 64'h4_0000_0000_0000), mk_f64(0, 1022, 0));
		add_item(mk_f64(1, 1021, 1), mk_f64(0, 1022, 0));
		add_item(mk_f64(0, 1021, 0), mk_f64(0, 1022, 0));
		add_item(mk_f64(0, 1023, MantMask), mk_f64(0, 1022, 0));
		add_item(mk_f64(0, 2047, 0), mk_f64(0, 1023, 0));
		add_item(mk_f64(1, 2047, 5), mk_f64(0, 1023, 0));
		add_item(mk_f64(0, 0, 7), mk_f64(0, 1023, 0));
		add_item(mk_f64(0, 100, 3), mk_f64(1, 1023, 0));
		add_item(mk_f64(0, 100, 3), mk_f64(0, 0, 9));
		add_item(mk_f64(0, 100, 3), mk_f64(0, 2047, 0));
		add_item(mk_f64(0, 1, 0), mk_f64(0, 1022, 0));
		add_item(mk_f64(0, 1, 0), mk_f64(0, 1023, 0));
		add_item(mk_f64(0, 2046, MantMask), mk_f64(0, 1022, 0));
		add_item(mk_f64(0, 2046, 0), mk_f64(0, 1, 0));
		add_item(mk_f64(0, 5, 0), mk_f64(0, 2046, 0));
		add_item(mk_f64(0, 2046, MantMask), mk_f64(0, 1000, 0));
		add_item(mk_f64(1, 1200, 1), mk_f64(0, 1100, 0));
		drain();

		random_phase(150, 0, 0);
		random_phase(120, 80, 0);
		random_phase(120, 0, 80);
		random_phase(120, 11, 11);

		// long receiver hold-off while the sender keeps offering items
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 60;
		repeat (40) pending_items.push_back(rand_item());
		drain();

		repeat (Latency + 10) @(posedge clk);
		if (mismatches == 0 && expected_rounds.size() == 0)
			$display("** float64_round_to_power_of_two_step: PASSED **");
		else
			$display("** float64_round_to_power_of_two_step: FAILED **");
		$finish;
	end
endmodule
